/* src/pcbqh_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the per-cycle base quality histogram.
// No dependencies; imported by every module of the block.
package pcbqh_pkg;

  localparam int CntW   = 32;
  localparam int QsumW  = 40;
  localparam int ReadW  = 32;
  localparam int LenW   = 48;
  localparam int PosW   = 17;
  localparam int CharW  = 8;
  localparam int CfgIdxW = 2;

  // Reset values of the configuration registers
  localparam logic [CharW-1:0] Q20ThrRst  = 8'd53;  // '5'
  localparam logic [CharW-1:0] Q30ThrRst  = 8'd63;  // '?'
  localparam logic [CharW-1:0] QualOffRst = 8'd33;

  // One histogram bin as stored in the bin memory
  typedef struct packed {
    logic [CntW-1:0]  q20;
    logic [CntW-1:0]  q30;
    logic [CntW-1:0]  cnt;
    logic [QsumW-1:0] qsum;
  } bin_t;

  typedef struct packed {
    logic [CharW-1:0] q20_thr;
    logic [CharW-1:0] q30_thr;
    logic [CharW-1:0] qual_off;
  } cfg_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_Q20_THR  = 2'd0,
    CFG_Q30_THR  = 2'd1,
    CFG_QUAL_OFF = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    OP_ACCUM = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  // Increment that sticks at all ones
  function automatic logic [CntW-1:0] sat_inc32(input logic [CntW-1:0] v);
    logic [CntW-1:0] r;
    r = (v == '1) ? v : v + CntW'(1);
    return r;
  endfunction

endpackage

/* src/pcbqh_bin_ram.sv */
`timescale 1ns / 1ps
// Bin memory: one write port, one read port with registered read data.
// Depends on pcbqh_pkg (bin_t).
module pcbqh_bin_ram import pcbqh_pkg::*; #(
  parameter int Depth = 8192,
  parameter int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  bin_t             wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output bin_t             rdata_o
);

  bin_t mem_q [Depth];
  bin_t rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, registered; data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/pcbqh_bin_update.sv */
`timescale 1ns / 1ps
// Bin update: classifies one base by quality and forms the new bin value.
// Depends on pcbqh_pkg (bin_t, cfg_t, sat_inc32).
module pcbqh_bin_update import pcbqh_pkg::*; (
  input  bin_t             cur_i,
  input  logic [CharW-1:0] qual_i,
  input  cfg_t             cfg_i,
  output bin_t             nxt_o
);

  logic             is_q30;
  logic             is_q20;
  logic [CharW-1:0] qdelta;
  logic [QsumW:0]   qsum_sum;

  always_comb begin
    // Q30 always implies Q20, whatever the threshold order
    is_q30 = (qual_i >= cfg_i.q30_thr);
    is_q20 = is_q30 || (qual_i >= cfg_i.q20_thr);
    // quality below the offset contributes nothing
    qdelta = (qual_i >= cfg_i.qual_off) ? (qual_i - cfg_i.qual_off) : '0;
    qsum_sum = {1'b0, cur_i.qsum} + (QsumW+1)'(qdelta);

    nxt_o.q20  = is_q20 ? sat_inc32(cur_i.q20) : cur_i.q20;
    nxt_o.q30  = is_q30 ? sat_inc32(cur_i.q30) : cur_i.q30;
    nxt_o.cnt  = sat_inc32(cur_i.cnt);
    nxt_o.qsum = qsum_sum[QsumW] ? '1 : qsum_sum[QsumW-1:0];
  end

endmodule

/* src/per_cycle_base_quality_histogram_unit.sv */
`timescale 1ns / 1ps
// Per-cycle base quality histogram, top level.
// Depends on pcbqh_pkg, pcbqh_bin_ram and pcbqh_bin_update.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one request: either an
//   accumulate of one base (binned on position in read and base class) or
//   a query of one bin. Every request produces exactly one result on the
//   output channel (out_valid_o/out_ready_i) with the bin counters (zero
//   for accumulate or an out-of-range query), the read and length
//   totals after the request, and a dropped flag for bases past capacity.
//   For each request, the accept issues the bin memory read, then the
//   execute state writes the updated bin back and loads the output
//   register. Only one request is in flight, so each bin read follows
//   the previous write-back. The output register lets the next request
//   be accepted while a result waits. If the receiver stalls and a
//   second result is ready, the block holds it in its execute state and
//   takes no new request until the output register frees up.
//   After reset all MAX_POSITIONS*8 bin memory entries (8192 by default)
//   are cleared one entry a cycle; in_ready_o stays low until then.
//   Configuration writes are taken at any time.
module per_cycle_base_quality_histogram_unit import pcbqh_pkg::*; #(
  parameter int MAX_POSITIONS = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration write port
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CharW-1:0]    cfg_data_i,
  // request channel
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                operation_i,
  input  logic [CharW-1:0]    base_char_i,
  input  logic [CharW-1:0]    quality_char_i,
  input  logic                end_of_read_i,
  input  logic [9:0]          query_position_i,
  input  logic [2:0]          query_class_i,
  // result channel
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [CntW-1:0]     q20_count_o,
  output logic [CntW-1:0]     q30_count_o,
  output logic [CntW-1:0]     base_count_o,
  output logic [QsumW-1:0]    quality_total_o,
  output logic [ReadW-1:0]    read_total_o,
  output logic [LenW-1:0]     length_total_o,
  output logic                dropped_o
);

  localparam int PosIdxW = $clog2(MAX_POSITIONS);
  localparam int Depth   = MAX_POSITIONS * 8;
  localparam int AddrW   = PosIdxW + 3;
  localparam logic [PosW-1:0]  MaxPos   = PosW'(MAX_POSITIONS);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(Depth - 1);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_e;

  state_e            state_q, state_d;
  logic [AddrW-1:0]  clr_cnt_q, clr_cnt_d;
  logic              out_valid_q, out_valid_d;
  logic [PosW-1:0]   pos_q, pos_d;
  logic [ReadW-1:0]  reads_q, reads_d;
  logic [LenW-1:0]   lengths_q, lengths_d;
  cfg_t              cfg_q, cfg_d;

  // captured request
  op_e               op_q;
  logic [CharW-1:0]  qual_q;
  logic              eor_q;
  logic              hit_q;
  logic [AddrW-1:0]  addr_q;

  // result register
  bin_t              out_bin_q;
  logic              out_drop_q;
  logic [ReadW-1:0]  out_reads_q;
  logic [LenW-1:0]   out_lengths_q;

  logic              in_fire;
  logic              finish;
  logic              accum_done;
  op_e               in_op;
  logic [PosW-1:0]   qpos_ext;
  logic              in_hit;
  logic [AddrW-1:0]  rd_addr;
  logic [LenW:0]     len_sum;

  logic              ram_we;
  logic [AddrW-1:0]  ram_waddr;
  bin_t              ram_wdata;
  bin_t              ram_rdata;
  bin_t              bin_nxt;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign finish     = (state_q == ST_EXEC) && (!out_valid_q || out_ready_i);
  assign accum_done = finish && (op_q == OP_ACCUM);

  // Bin address of the incoming request
  always_comb begin
    in_op    = op_e'(operation_i);
    qpos_ext = PosW'(query_position_i);
    if (in_op == OP_QUERY) begin
      in_hit  = (qpos_ext < MaxPos);
      rd_addr = {qpos_ext[PosIdxW-1:0], query_class_i};
    end else begin
      in_hit  = (pos_q < MaxPos);
      rd_addr = {pos_q[PosIdxW-1:0], base_char_i[2:0]};
    end
  end

  pcbqh_bin_ram #(
    .Depth (Depth),
    .AddrW (AddrW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (in_fire),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  pcbqh_bin_update u_upd (
    .cur_i  (ram_rdata),
    .qual_i (qual_q),
    .cfg_i  (cfg_q),
    .nxt_o  (bin_nxt)
  );

  // Write port: clearing sweep after reset, else bin write-back
  always_comb begin
    if (state_q == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_q;
      ram_wdata = '0;
    end else begin
      ram_we    = accum_done && hit_q;
      ram_waddr = addr_q;
      ram_wdata = bin_nxt;
    end
  end

  // Next state, totals and configuration
  always_comb begin
    state_d     = state_q;
    clr_cnt_d   = clr_cnt_q;
    out_valid_d = out_valid_q;
    pos_d       = pos_q;
    reads_d     = reads_q;
    lengths_d   = lengths_q;
    cfg_d       = cfg_q;
    len_sum     = {1'b0, lengths_q} + (LenW+1)'(pos_q) + (LenW+1)'(1);

    case (state_q)
      ST_CLEAR: begin
        clr_cnt_d = clr_cnt_q + AddrW'(1);
        if (clr_cnt_q == LastAddr) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (finish) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // result handoff
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (finish) begin
      out_valid_d = 1'b1;
    end

    // read position and totals
    if (accum_done) begin
      if (eor_q) begin
        reads_d   = sat_inc32(reads_q);
        lengths_d = len_sum[LenW] ? '1 : len_sum[LenW-1:0];
        pos_d     = '0;
      end else if (pos_q != '1) begin
        pos_d = pos_q + PosW'(1);
      end
    end

    // configuration writes
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_Q20_THR:  cfg_d.q20_thr  = cfg_data_i;
        CFG_Q30_THR:  cfg_d.q30_thr  = cfg_data_i;
        CFG_QUAL_OFF: cfg_d.qual_off = cfg_data_i;
        default: ;
      endcase
    end
  end

  // Control state and registered handshake outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_CLEAR;
      clr_cnt_q     <= '0;
      out_valid_q   <= 1'b0;
      pos_q         <= '0;
      reads_q       <= '0;
      lengths_q     <= '0;
      cfg_q.q20_thr <= Q20ThrRst;
      cfg_q.q30_thr <= Q30ThrRst;
      cfg_q.qual_off <= QualOffRst;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      out_valid_q <= out_valid_d;
      pos_q       <= pos_d;
      reads_q     <= reads_d;
      lengths_q   <= lengths_d;
      cfg_q       <= cfg_d;
    end
  end

  // Request capture and result payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q   <= in_op;
      qual_q <= quality_char_i;
      eor_q  <= end_of_read_i;
      hit_q  <= in_hit;
      addr_q <= rd_addr;
    end
    if (finish) begin
      out_bin_q     <= (op_q == OP_QUERY && hit_q) ? ram_rdata : '0;
      out_drop_q    <= (op_q == OP_ACCUM) && !hit_q;
      out_reads_q   <= reads_d;
      out_lengths_q <= lengths_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign q20_count_o     = out_bin_q.q20;
  assign q30_count_o     = out_bin_q.q30;
  assign base_count_o    = out_bin_q.cnt;
  assign quality_total_o = out_bin_q.qsum;
  assign read_total_o    = out_reads_q;
  assign length_total_o  = out_lengths_q;
  assign dropped_o       = out_drop_q;

endmodule

/* src/pcbqh_checker.sv */
`timescale 1ns / 1ps
// Port-level checks of the histogram unit, bound to the top level.
// Depends on pcbqh_pkg and per_cycle_base_quality_histogram_unit.
module pcbqh_checker import pcbqh_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input logic [CntW-1:0]     q20_count_o,
  input logic [CntW-1:0]     q30_count_o,
  input logic [CntW-1:0]     base_count_o,
  input logic [QsumW-1:0]    quality_total_o,
  input logic [ReadW-1:0]    read_total_o,
  input logic [LenW-1:0]     length_total_o,
  input logic                dropped_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(read_total_o)
      && $stable(length_total_o) && $stable(base_count_o) && $stable(dropped_o))
    else $error("result changed while stalled");

  // one request in flight: no accept right after an accept
  a_one_inflight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request accepted while previous one executes");

  // a dropped base carries no bin counters
  a_drop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && dropped_o |-> q20_count_o == '0 && q30_count_o == '0
      && base_count_o == '0 && quality_total_o == '0)
    else $error("dropped result with nonzero bin");

  // no completed read means no summed length
  a_len_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && read_total_o == '0 |-> length_total_o == '0)
    else $error("length total without a completed read");

endmodule

bind per_cycle_base_quality_histogram_unit pcbqh_checker u_pcbqh_checker (.*);
